/* rtl/core/gfli_pkg.sv */
package gfli_pkg;

  // Default depth of the gap store.
  localparam int MAX_GAP_DEF = 63;

  // Widths of the sample fields.
  localparam int FRAME_W = 32;
  localparam int COORD_W = 24;
  localparam int CONF_W  = 16;
  localparam int TRACK_W = 16;

  // One held blank: its frame and its own coordinates.
  typedef struct packed {
    logic [FRAME_W-1:0]        frame;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } gap_entry_t;

  // Request to the shared interpolation unit: a + (b - a) * d / n.
  typedef struct packed {
    logic                      start;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic [FRAME_W-1:0]        d;
    logic [FRAME_W-1:0]        n;
  } lerp_req_t;

  // Response of the interpolation unit, valid for the one cycle with done set.
  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] value;
  } lerp_rsp_t;

endpackage

/* rtl/core/gfli_gap_mem.sv */
module gfli_gap_mem #(
  parameter int DEPTH  = gfli_pkg::MAX_GAP_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  gfli_pkg::gap_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output gfli_pkg::gap_entry_t rd_data
);
  import gfli_pkg::*;

  gap_entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/gfli_lerp.sv */
module gfli_lerp (
  input  logic                clk,
  input  logic                rst,
  input  gfli_pkg::lerp_req_t req,
  output gfli_pkg::lerp_rsp_t rsp
);
  import gfli_pkg::*;

  // Quotient bits: the rounded quotient never exceeds |b - a| < 2^24.
  localparam int Q_W    = COORD_W;
  localparam int STEP_W = $clog2(Q_W);
  localparam int PROD_W = COORD_W + FRAME_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int REM_W  = FRAME_W + 1;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_MUL  = 5'b00010,
    L_LOAD = 5'b00100,
    L_DIV  = 5'b01000,
    L_DONE = 5'b10000
  } lstate_t;

  lstate_t                   state;
  logic signed [COORD_W-1:0] a_r;
  logic signed [COORD_W-1:0] b_r;
  logic                      neg;
  logic                      zero_n;
  logic [COORD_W-1:0]        mag;
  logic [FRAME_W-1:0]        dcl;
  logic [FRAME_W-1:0]        n_r;
  logic [PROD_W-1:0]         prod;
  logic [REM_W-1:0]          rem;
  logic [Q_W-1:0]            quo;
  logic [STEP_W-1:0]         step;

  logic signed [COORD_W:0]   delta;
  logic [COORD_W-1:0]        mag_in;
  logic [NUM_W-1:0]          num;
  logic [REM_W:0]            sh;
  logic [REM_W+1:0]          diff;
  logic                      borrow;

  // Difference and its magnitude at the start of a request.
  assign delta  = (COORD_W+1)'(req.b) - (COORD_W+1)'(req.a);
  assign mag_in = delta[COORD_W] ? COORD_W'(-delta) : delta[COORD_W-1:0];

  // Rounded numerator 2*|b-a|*d + n; it stays below 2^24 times the divisor.
  assign num = {prod, 1'b0} + NUM_W'(n_r);

  // One restoring division step against the divisor 2*n.
  assign sh     = {rem, quo[Q_W-1]};
  assign diff   = {1'b0, sh} - (REM_W+2)'({n_r, 1'b0});
  assign borrow = diff[REM_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (req.start) begin
            a_r    <= req.a;
            b_r    <= req.b;
            neg    <= delta[COORD_W];
            mag    <= mag_in;
            dcl    <= (req.d > req.n) ? req.n : req.d;
            n_r    <= req.n;
            zero_n <= (req.n == '0);
            state  <= (req.n == '0) ? L_DONE : L_MUL;
          end
        end
        L_MUL: begin
          prod  <= PROD_W'(mag) * PROD_W'(dcl);
          state <= L_LOAD;
        end
        L_LOAD: begin
          rem   <= num[NUM_W-1:Q_W];
          quo   <= num[Q_W-1:0];
          step  <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          rem  <= borrow ? sh[REM_W-1:0] : diff[REM_W-1:0];
          quo  <= {quo[Q_W-2:0], ~borrow};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(Q_W - 1)) begin
            state <= L_DONE;
          end
        end
        L_DONE: begin
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  // Result lies between a and b; equal frames give b.
  assign rsp.done  = (state == L_DONE);
  assign rsp.value = zero_n ? b_r : (neg ? (a_r - $signed(quo)) : (a_r + $signed(quo)));

endmodule

/* rtl/core/gap_fill_linear_interpolator_top.sv */
// A blank sample that is held releases nothing. Otherwise each held blank is read back
// from the gap store and released, unfilled or interpolated between anchors in
// three passes (x, y, conf) of the shared multiply and 24-step serial divider, and
// the sample itself is released last.
// Throughput: one sample at a time; the input is not ready until its last result is loaded.
// Reset (rst, synchronous): clears anchor, gap count, track and output valid.
module gap_fill_linear_interpolator_top #(
  parameter int MAX_GAP = gfli_pkg::MAX_GAP_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_index[31:0], coord_x[55:32], coord_y[79:56], conf[95:80], track_id[111:96]
  input  logic [111:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_frame[31:0], out_x[55:32], out_y[79:56], out_conf[95:80], out_track[111:96]
  output logic [111:0] m_tdata,
  // filled[0], overflow[1]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  import gfli_pkg::*;

  localparam int CNT_W = $clog2(MAX_GAP + 1);
  localparam int IDX_W = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_GO   = 6'b000100,
    S_WAIT = 6'b001000,
    S_EMIT = 6'b010000,
    S_SELF = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    MODE_VALID = 3'b001,
    MODE_END   = 3'b010,
    MODE_OVF   = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    FLD_X = 3'b001,
    FLD_Y = 3'b010,
    FLD_C = 3'b100
  } fld_t;

  state_t                    state;
  mode_t                     mode;
  fld_t                      fsel;

  logic [FRAME_W-1:0]        cur_frame;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic [CONF_W-1:0]         cur_conf;
  logic [TRACK_W-1:0]        cur_track;
  logic                      cur_end;
  logic [TRACK_W-1:0]        held_track;
  logic [TRACK_W-1:0]        current_track;

  logic                      anchor_valid;
  logic [FRAME_W-1:0]        anchor_frame;
  logic signed [COORD_W-1:0] anchor_x;
  logic signed [COORD_W-1:0] anchor_y;
  logic [CONF_W-1:0]         anchor_conf;

  logic [CNT_W-1:0]          gap_count;
  logic [CNT_W-1:0]          idx;
  logic signed [COORD_W-1:0] fx;
  logic signed [COORD_W-1:0] fy;
  logic [CONF_W-1:0]         fc;

  // Input fields.
  logic [FRAME_W-1:0]        in_frame;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic [CONF_W-1:0]         in_conf;
  logic [TRACK_W-1:0]        in_track;
  logic                      accept;
  logic                      store;

  gap_entry_t                wr_data;
  gap_entry_t                rd_data;
  logic                      rd_en;
  lerp_req_t                 lreq;
  lerp_rsp_t                 lrsp;
  logic                      out_free;
  logic                      last_gap;

  assign in_frame = s_tdata[31:0];
  assign in_x     = s_tdata[55:32];
  assign in_y     = s_tdata[79:56];
  assign in_conf  = s_tdata[95:80];
  assign in_track = s_tdata[111:96];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // A blank that neither ends the track nor finds the store full is held.
  assign store = accept && (in_conf == '0) && !s_tlast && (gap_count < CNT_W'(MAX_GAP));

  assign wr_data.frame = in_frame;
  assign wr_data.x     = in_x;
  assign wr_data.y     = in_y;
  assign rd_en         = (state == S_READ);

  gfli_gap_mem #(
    .DEPTH  (MAX_GAP),
    .ADDR_W (IDX_W)
  ) u_gap_mem (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (gap_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Operands for the shared interpolation unit, one field per pass.
  always_comb begin
    lreq.start = (state == S_GO);
    lreq.d     = rd_data.frame - anchor_frame;
    lreq.n     = cur_frame - anchor_frame;
    unique case (fsel)
      FLD_X: begin
        lreq.a = anchor_x;
        lreq.b = cur_x;
      end
      FLD_Y: begin
        lreq.a = anchor_y;
        lreq.b = cur_y;
      end
      FLD_C: begin
        lreq.a = COORD_W'(anchor_conf);
        lreq.b = COORD_W'(cur_conf);
      end
      default: begin
        lreq.a = anchor_x;
        lreq.b = cur_x;
      end
    endcase
  end

  gfli_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .req (lreq),
    .rsp (lrsp)
  );

  // The output register takes a new transaction when empty or being drained.
  assign out_free = !m_tvalid || m_tready;
  assign last_gap = ((idx + CNT_W'(1)) == gap_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      gap_count     <= '0;
      anchor_valid  <= 1'b0;
      anchor_frame  <= '0;
      anchor_x      <= '0;
      anchor_y      <= '0;
      anchor_conf   <= '0;
      current_track <= '0;
    end else begin
      // A taken result empties the register unless a new one is loaded below.
      if (m_tvalid && m_tready && (state != S_EMIT) && (state != S_SELF)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        // Take a sample and decide what it releases.
        S_IDLE: begin
          if (accept) begin
            cur_frame     <= in_frame;
            cur_x         <= in_x;
            cur_y         <= in_y;
            cur_conf      <= in_conf;
            cur_track     <= in_track;
            cur_end       <= s_tlast;
            held_track    <= current_track;
            current_track <= in_track;
            idx           <= '0;
            if (store) begin
              gap_count <= gap_count + CNT_W'(1);
            end else begin
              if (in_conf != '0) begin
                mode <= MODE_VALID;
              end else if (s_tlast) begin
                mode <= MODE_END;
              end else begin
                mode <= MODE_OVF;
              end
              state <= (gap_count == '0) ? S_SELF : S_READ;
            end
          end
        end
        // Fetch the next held blank.
        S_READ: begin
          fsel <= FLD_X;
          if ((mode == MODE_VALID) && anchor_valid) begin
            state <= S_GO;
          end else begin
            state <= S_EMIT;
          end
        end
        S_GO: begin
          state <= S_WAIT;
        end
        // Collect one interpolated field and move on to the next.
        S_WAIT: begin
          if (lrsp.done) begin
            unique case (fsel)
              FLD_X: begin
                fx    <= lrsp.value;
                fsel  <= FLD_Y;
                state <= S_GO;
              end
              FLD_Y: begin
                fy    <= lrsp.value;
                fsel  <= FLD_C;
                state <= S_GO;
              end
              FLD_C: begin
                fc    <= lrsp.value[CONF_W-1:0];
                state <= S_EMIT;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        // Release one held blank.
        S_EMIT: begin
          if (out_free) begin
            m_tvalid            <= 1'b1;
            m_tlast             <= 1'b0;
            m_tdata[31:0]       <= rd_data.frame;
            m_tdata[111:96]     <= held_track;
            unique case (mode)
              MODE_VALID: begin
                m_tdata[55:32] <= anchor_valid ? fx : cur_x;
                m_tdata[79:56] <= anchor_valid ? fy : cur_y;
                m_tdata[95:80] <= anchor_valid ? fc : cur_conf;
                m_tuser        <= 2'b01;
              end
              MODE_END: begin
                m_tdata[55:32] <= anchor_valid ? anchor_x : rd_data.x;
                m_tdata[79:56] <= anchor_valid ? anchor_y : rd_data.y;
                m_tdata[95:80] <= anchor_valid ? anchor_conf : '0;
                m_tuser        <= {1'b0, anchor_valid};
              end
              MODE_OVF: begin
                m_tdata[55:32] <= rd_data.x;
                m_tdata[79:56] <= rd_data.y;
                m_tdata[95:80] <= '0;
                m_tuser        <= 2'b10;
              end
              default: begin
                m_tdata[55:32] <= rd_data.x;
                m_tdata[79:56] <= rd_data.y;
                m_tdata[95:80] <= '0;
                m_tuser        <= 2'b00;
              end
            endcase
            if (last_gap) begin
              state <= S_SELF;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_READ;
            end
          end
        end
        // Release the sample itself and, unless the store overflowed, update the anchor.
        S_SELF: begin
          if (out_free) begin
            m_tvalid        <= 1'b1;
            m_tlast         <= 1'b1;
            m_tdata[31:0]   <= cur_frame;
            m_tdata[111:96] <= cur_track;
            gap_count       <= '0;
            state           <= S_IDLE;
            unique case (mode)
              MODE_VALID: begin
                m_tdata[55:32] <= cur_x;
                m_tdata[79:56] <= cur_y;
                m_tdata[95:80] <= cur_conf;
                m_tuser        <= 2'b00;
                anchor_valid   <= !cur_end;
                anchor_frame   <= cur_frame;
                anchor_x       <= cur_x;
                anchor_y       <= cur_y;
                anchor_conf    <= cur_conf;
              end
              MODE_END: begin
                m_tdata[55:32] <= anchor_valid ? anchor_x : cur_x;
                m_tdata[79:56] <= anchor_valid ? anchor_y : cur_y;
                m_tdata[95:80] <= anchor_valid ? anchor_conf : '0;
                m_tuser        <= {1'b0, anchor_valid};
                anchor_valid   <= 1'b0;
              end
              MODE_OVF: begin
                m_tdata[55:32] <= cur_x;
                m_tdata[79:56] <= cur_y;
                m_tdata[95:80] <= '0;
                m_tuser        <= 2'b10;
              end
              default: begin
                m_tdata[55:32] <= cur_x;
                m_tdata[79:56] <= cur_y;
                m_tdata[95:80] <= '0;
                m_tuser        <= 2'b00;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/gfli_checker.sv */
`timescale 1ns / 1ps

// Watches both stream channels of the gap filler, predicts every released sample
// from the accepted input samples, and compares each result transaction with the
// oldest prediction.
module gfli_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // frame_index[31:0], coord_x[55:32], coord_y[79:56], conf[95:80], track_id[111:96]
  input  logic [111:0] s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // out_frame[31:0], out_x[55:32], out_y[79:56], out_conf[95:80], out_track[111:96]
  input  logic [111:0] m_tdata,
  // filled[0], overflow[1]
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  output int           errors,
  output int           pending,
  output int           results_out,
  output int           filled_out,
  output int           overflow_out
);

  localparam int GAP_DEPTH = gfli_pkg::MAX_GAP_DEF;

  // One released sample as it appears on the result channel.
  typedef struct packed {
    logic [gfli_pkg::FRAME_W-1:0]        frame;
    logic signed [gfli_pkg::COORD_W-1:0] x;
    logic signed [gfli_pkg::COORD_W-1:0] y;
    logic [gfli_pkg::CONF_W-1:0]         conf;
    logic [gfli_pkg::TRACK_W-1:0]        track;
    logic                                filled;
    logic                                overflow;
    logic                                run_last;
  } released_t;

  // Anchor: the last valid sample of the current track.
  logic                                anc_valid;
  logic [gfli_pkg::FRAME_W-1:0]        anc_frame;
  logic signed [gfli_pkg::COORD_W-1:0] anc_x;
  logic signed [gfli_pkg::COORD_W-1:0] anc_y;
  logic [gfli_pkg::CONF_W-1:0]         anc_conf;
  logic [gfli_pkg::TRACK_W-1:0]        cur_track;

  // Blanks waiting for the next valid sample.
  logic [gfli_pkg::FRAME_W-1:0]        held_frame [GAP_DEPTH];
  logic signed [gfli_pkg::COORD_W-1:0] held_x     [GAP_DEPTH];
  logic signed [gfli_pkg::COORD_W-1:0] held_y     [GAP_DEPTH];
  int                                  held_cnt;

  released_t released_q[$];

  // Linear interpolation a + (b - a) * d / n with the quotient rounded to nearest,
  // halves away from zero. An offset past the span is clamped to the span.
  function automatic longint interp_field(input longint a, input longint b,
                                          input logic [31:0] offs_in,
                                          input logic [31:0] span);
    logic [31:0]     offs;
    longint          delta;
    longint unsigned mag;
    longint unsigned quot;
    offs = offs_in;
    if (span == 0) return b;
    if (offs > span) offs = span;
    delta = b - a;
    mag   = (delta < 0) ? -delta : delta;
    quot  = (64'd2 * mag * offs + span) / (64'd2 * span);
    return (delta < 0) ? a - longint'(quot) : a + longint'(quot);
  endfunction

  function automatic released_t make_release(input logic [31:0] frame, input longint x,
                                             input longint y, input longint conf,
                                             input logic [15:0] track, input logic filled,
                                             input logic overflow);
    released_t r;
    r.frame    = frame;
    r.x        = x[23:0];
    r.y        = y[23:0];
    r.conf     = conf[15:0];
    r.track    = track;
    r.filled   = filled;
    r.overflow = overflow;
    r.run_last = 1'b0;
    return r;
  endfunction

  function automatic string describe(input released_t r);
    return $sformatf("frame %h x %h y %h conf %h track %h filled %b ovf %b last %b",
                     r.frame, r.x, r.y, r.conf, r.track, r.filled, r.overflow, r.run_last);
  endfunction

  // Works out every sample released by one input transaction and queues them.
  task automatic predict_release(input logic [31:0] frame, input logic signed [23:0] x,
                                 input logic signed [23:0] y, input logic [15:0] conf,
                                 input logic [15:0] track, input logic track_end);
    released_t   batch[$];
    logic [15:0] held_track;
    logic [31:0] span;
    logic [31:0] offs;
    int          i;
    held_track = cur_track;
    cur_track  = track;
    if (conf != 0) begin
      // A valid sample fills the held blanks, then goes out itself.
      span = frame - anc_frame;
      for (i = 0; i < held_cnt; i++) begin
        if (anc_valid) begin
          offs = held_frame[i] - anc_frame;
          batch.push_back(make_release(held_frame[i], interp_field(anc_x, x, offs, span),
                                       interp_field(anc_y, y, offs, span),
                                       interp_field(anc_conf, conf, offs, span),
                                       held_track, 1'b1, 1'b0));
        end else begin
          batch.push_back(make_release(held_frame[i], x, y, conf, held_track, 1'b1, 1'b0));
        end
      end
      batch.push_back(make_release(frame, x, y, conf, track, 1'b0, 1'b0));
      held_cnt  = 0;
      anc_valid = !track_end;
      anc_frame = frame;
      anc_x     = x;
      anc_y     = y;
      anc_conf  = conf;
    end else if (track_end) begin
      // A blank closing the track: trailing blanks take the anchor if there is one.
      for (i = 0; i < held_cnt; i++) begin
        if (anc_valid)
          batch.push_back(make_release(held_frame[i], anc_x, anc_y, anc_conf, held_track,
                                       1'b1, 1'b0));
        else
          batch.push_back(make_release(held_frame[i], held_x[i], held_y[i], 0, held_track,
                                       1'b0, 1'b0));
      end
      if (anc_valid)
        batch.push_back(make_release(frame, anc_x, anc_y, anc_conf, track, 1'b1, 1'b0));
      else
        batch.push_back(make_release(frame, x, y, 0, track, 1'b0, 1'b0));
      held_cnt  = 0;
      anc_valid = 1'b0;
    end else if (held_cnt < GAP_DEPTH) begin
      held_frame[held_cnt] = frame;
      held_x[held_cnt]     = x;
      held_y[held_cnt]     = y;
      held_cnt++;
    end else begin
      // Gap store full: everything held goes out unfilled, the anchor stays.
      for (i = 0; i < held_cnt; i++)
        batch.push_back(make_release(held_frame[i], held_x[i], held_y[i], 0, held_track,
                                     1'b0, 1'b1));
      batch.push_back(make_release(frame, x, y, 0, track, 1'b0, 1'b1));
      held_cnt = 0;
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
    foreach (batch[j]) released_q.push_back(batch[j]);
  endtask

  // Results are handled before inputs: no result can stem from a sample accepted
  // at the same edge.
  always @(posedge clk) begin
    released_t got;
    released_t want;
    if (rst) begin
      anc_valid = 1'b0;
      anc_frame = '0;
      anc_x     = '0;
      anc_y     = '0;
      anc_conf  = '0;
      cur_track = '0;
      held_cnt  = 0;
      released_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.frame    = m_tdata[31:0];
        got.x        = m_tdata[55:32];
        got.y        = m_tdata[79:56];
        got.conf     = m_tdata[95:80];
        got.track    = m_tdata[111:96];
        got.filled   = m_tuser[0];
        got.overflow = m_tuser[1];
        got.run_last = m_tlast;
        results_out++;
        if (got.filled) filled_out++;
        if (got.overflow) overflow_out++;
        if (released_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %s", describe(got));
        end else begin
          want = released_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("result mismatch, expected: %s", describe(want));
              $display("                   actual: %s", describe(got));
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_release(s_tdata[31:0], s_tdata[55:32], s_tdata[79:56], s_tdata[95:80],
                        s_tdata[111:96], s_tlast);
    end
    pending <= released_q.size();
  end

endmodule

/* tb/tb_gap_fill_linear_interpolator_top.sv */
`timescale 1ns / 1ps

module tb_gap_fill_linear_interpolator_top;

  localparam int GAP_DEPTH      = gfli_pkg::MAX_GAP_DEF;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PHASE_SAMPLES  = 65;

  typedef enum int {
    TRACK_MIXED,
    TRACK_ALL_BLANK,
    TRACK_OVERFLOW,
    TRACK_FULL_GAP
  } track_kind_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // frame_index[31:0], coord_x[55:32], coord_y[79:56], conf[95:80], track_id[111:96]
  logic [111:0] s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // out_frame[31:0], out_x[55:32], out_y[79:56], out_conf[95:80], out_track[111:96]
  logic [111:0] m_tdata;
  // filled[0], overflow[1]
  logic [1:0]   m_tuser;
  logic         m_tlast;

  int err_count;
  int pending_cnt;
  int results_cnt;
  int filled_cnt;
  int overflow_cnt;

  int samples_sent = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  gap_fill_linear_interpolator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  gfli_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .errors       (err_count),
    .pending      (pending_cnt),
    .results_out  (results_cnt),
    .filled_out   (filled_cnt),
    .overflow_out (overflow_cnt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      m_tready    <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 24'h80_0000;
      1:       return 24'h7F_FFFF;
      2:       return 24'($urandom_range(0, 7));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_conf();
    case ($urandom_range(0, 9))
      0:       return 16'h0001;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Offers one sample, with random idle cycles ahead of it, until it is taken.
  task automatic send_sample(input logic [31:0] frame, input logic [23:0] x,
                             input logic [23:0] y, input logic [15:0] conf,
                             input logic [15:0] track, input logic track_end);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
      s_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {track, conf, y, x, frame};
    s_tlast  <= track_end;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // Hand-picked samples: leading blanks, extreme coordinates, rounding of halves,
  // equal and out-of-order frames, both kinds of track end, an all-blank track,
  // a frame counter wrap and a track id change without a track end.
  task automatic run_directed();
    send_sample(32'd10, 24'h7F_FFFF, 24'h80_0000, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd11, 24'h00_0000, 24'h00_0000, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd12, 24'h7F_FFFF, 24'h80_0000, 16'hFFFF, 16'h0001, 1'b0);
    send_sample(32'd13, 24'h12_3456, 24'h65_4321, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd16, 24'h00_0000, 24'h00_0000, 16'h0001, 16'h0001, 1'b0);
    send_sample(32'd17, 24'h55_5555, 24'hAA_AAAA, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd18, 24'h00_0001, 24'hFF_FFFF, 16'h0003, 16'h0001, 1'b0);
    send_sample(32'd18, 24'h00_0010, 24'h00_0020, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd18, 24'h80_0000, 24'h7F_FFFF, 16'h8000, 16'h0001, 1'b0);
    send_sample(32'd30, 24'h00_0000, 24'h00_0000, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd25, 24'h7F_FFFF, 24'h80_0000, 16'h0100, 16'h0001, 1'b0);
    send_sample(32'd26, 24'h00_0000, 24'h00_0000, 16'h0000, 16'h0001, 1'b0);
    send_sample(32'd27, 24'hFF_FF00, 24'h00_0100, 16'h7FFF, 16'h0001, 1'b1);
    send_sample(32'd100, 24'h01_0000, 24'hFE_0000, 16'h1234, 16'hFFFF, 1'b0);
    send_sample(32'd101, 24'h00_0000, 24'h00_0000, 16'h0000, 16'hFFFF, 1'b0);
    send_sample(32'd102, 24'h00_0000, 24'h00_0000, 16'h0000, 16'hFFFF, 1'b1);
    send_sample(32'd0, 24'h80_0000, 24'h7F_FFFF, 16'h0000, 16'h0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 16'h0000, 16'h0000, 1'b1);
    send_sample(32'hFFFF_FFFE, 24'h00_1000, 24'hFF_F000, 16'h4000, 16'h5555, 1'b0);
    send_sample(32'hFFFF_FFFF, 24'h00_0000, 24'h00_0000, 16'h0000, 16'h5555, 1'b0);
    send_sample(32'd1, 24'hFF_F000, 24'h00_1000, 16'hC000, 16'hAAAA, 1'b1);
    send_sample(32'd7, 24'h00_0123, 24'h00_0456, 16'h0789, 16'h0002, 1'b1);
  endtask

  // One track of random content. Mixed tracks carry some broken order: repeated
  // and backward frames, big frame jumps, id changes and a missing track end.
  task automatic gen_track(input track_kind_t kind);
    logic [31:0] frame;
    logic [15:0] trk;
    logic [15:0] conf;
    int          len;
    int          blank_pct;
    int          r;
    int          i;
    trk = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       frame = $urandom_range(0, 15);
      1:       frame = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: frame = $urandom;
    endcase
    if (kind == TRACK_OVERFLOW || kind == TRACK_FULL_GAP) begin
      // An anchor, then enough blanks to fill (or overrun) the gap store.
      send_sample(frame, rand_coord(), rand_coord(), rand_conf(), trk, 1'b0);
      len = (kind == TRACK_OVERFLOW) ? GAP_DEPTH + 4 : GAP_DEPTH;
      for (i = 0; i < len; i++) begin
        frame = frame + $urandom_range(1, 3);
        send_sample(frame, rand_coord(), rand_coord(), 16'h0000, trk, 1'b0);
      end
      frame = frame + $urandom_range(1, 3);
      conf  = ($urandom_range(0, 1) != 0) ? rand_conf() : 16'h0000;
      send_sample(frame, rand_coord(), rand_coord(), conf, trk, 1'b1);
    end else begin
      len       = (kind == TRACK_ALL_BLANK) ? $urandom_range(1, 5) : $urandom_range(1, 14);
      blank_pct = (kind == TRACK_ALL_BLANK) ? 100 : $urandom_range(0, 70);
      for (i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (i > 0) begin
          if (r >= 6 && r < 10)
            frame = frame - $urandom_range(1, 5);
          else if (r >= 10 && r < 14)
            frame = frame + $urandom;
          else if (r >= 14)
            frame = frame + $urandom_range(1, 3);
        end
        if ($urandom_range(0, 99) < 4) trk = 16'($urandom);
        conf = ($urandom_range(0, 99) < blank_pct) ? 16'h0000 : rand_conf();
        send_sample(frame, rand_coord(), rand_coord(), conf, trk,
                    (i == len - 1) && ($urandom_range(0, 19) != 0));
      end
    end
  endtask

  initial begin
    int phase;
    int phase_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Random tracks under four pacing patterns.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 51; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 51; end
        default: begin idle_pct = 22; stall_pct <= 22; end
      endcase
      phase_start = samples_sent;
      if (phase == 1) gen_track(TRACK_OVERFLOW);
      if (phase == 2) hold_reqs <= hold_reqs + 1;
      if (phase == 3) gen_track(TRACK_FULL_GAP);
      while (samples_sent - phase_start < PHASE_SAMPLES)
        gen_track(($urandom_range(0, 9) == 0) ? TRACK_ALL_BLANK : TRACK_MIXED);
    end
    s_tvalid <= 1'b0;

    // Drain, then leave room for any stray result.
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d input samples and %0d results (%0d filled, %0d overflow)",
             samples_sent, results_cnt, filled_cnt, overflow_cnt);
    $display("pacing: free flow, sender gaps, receiver stalls, both, and a %0d-cycle hold",
             HOLD_CYCLES);
    if (err_count == 0 && pending_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
